// File: sv/u8lcd_pkg.sv
package u8lcd_pkg;

	// pending multi-byte sequence, codes above PEND_E2_BAD are never entered
	typedef enum logic [2:0] {
		PEND_IDLE   = 3'd0,
		PEND_C3     = 3'd1,
		PEND_E2     = 3'd2,
		PEND_E2_86  = 3'd3,
		PEND_E2_BAD = 3'd4
	} pend_t;

	// input bytes with a special meaning
	localparam logic [7:0] CH_BACKSLASH = 8'h5C;
	localparam logic [7:0] CH_TILDE     = 8'h7E;
	localparam logic [7:0] LEAD_C3      = 8'hC3;
	localparam logic [7:0] LEAD_E2      = 8'hE2;
	localparam logic [7:0] CONT_86      = 8'h86;
	localparam logic [7:0] CONT_AE_LO   = 8'hA4;
	localparam logic [7:0] CONT_OE_LO   = 8'hB6;
	localparam logic [7:0] CONT_UE_LO   = 8'hBC;
	localparam logic [7:0] CONT_AE_UP   = 8'h84;
	localparam logic [7:0] CONT_OE_UP   = 8'h96;
	localparam logic [7:0] CONT_UE_UP   = 8'h9C;
	localparam logic [7:0] CONT_SZ      = 8'h9F;
	localparam logic [7:0] CONT_LARROW  = 8'h90;
	localparam logic [7:0] CONT_RARROW  = 8'h92;

	// display codes
	localparam logic [7:0] LCD_BACKSLASH = 8'h01;
	localparam logic [7:0] LCD_TILDE     = 8'h02;
	localparam logic [7:0] LCD_AE_UP     = 8'h03;
	localparam logic [7:0] LCD_OE_UP     = 8'h04;
	localparam logic [7:0] LCD_UE_UP     = 8'h05;
	localparam logic [7:0] LCD_SZ        = 8'h06;
	localparam logic [7:0] LCD_AE_LO     = 8'hE1;
	localparam logic [7:0] LCD_OE_LO     = 8'hEF;
	localparam logic [7:0] LCD_UE_LO     = 8'hF5;
	localparam logic [7:0] LCD_LARROW    = 8'h7F;
	localparam logic [7:0] LCD_RARROW    = 8'h7E;

	typedef struct packed {
		logic       char_valid;
		logic [7:0] char_code;
		logic       line_done;
	} res_t;

endpackage

// File: sv/u8lcd_ifs.sv
interface u8lcd_text_if;
	logic       valid;
	logic       ready;
	logic [7:0] text_byte;
	logic       line_end;

	modport source (output valid, output text_byte, output line_end, input ready);
	modport sink (input valid, input text_byte, input line_end, output ready);
endinterface

interface u8lcd_char_if;
	logic       valid;
	logic       ready;
	logic       char_valid;
	logic [7:0] char_code;
	logic       line_done;

	modport source (output valid, output char_valid, output char_code, output line_done,
		input ready);
	modport sink (input valid, input char_valid, input char_code, input line_done,
		output ready);
endinterface

// File: sv/utf8_to_lcd_charset_mapper_top.sv
// channel  dir  fields                            handshake
// text     in   text_byte[7:0], line_end          valid/ready
// chars    out  char_valid, char_code[7:0],       valid/ready
//               line_done
//
// one result per request
// one request per cycle sustained while chars.ready holds; input register then result register
// the pending lead-byte state advances when a request leaves the input register
// arst_n clears both stage valids and the pending state
// a stalled result holds the result register and backs up into the input register
module utf8_to_lcd_charset_mapper_top import u8lcd_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	u8lcd_text_if.sink   text,
	u8lcd_char_if.source chars
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;
	logic       space;
	logic       adv;
	res_t       res;

	assign adv        = valid_s1 && space;
	assign text.ready = !valid_s1 || space;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (text.ready) begin
			valid_s1 <= text.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (text.valid && text.ready) begin
			byte_s1 <= text.text_byte;
			last_s1 <= text.line_end;
		end
	end

	u8lcd_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.text_byte (byte_s1),
		.line_end  (last_s1),
		.res       (res)
	);

	u8lcd_out_reg u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (valid_s1),
		.res      (res),
		.space    (space),
		.chars    (chars)
	);

endmodule

// File: sv/u8lcd_seq.sv
module u8lcd_seq import u8lcd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       adv,
	input  logic [7:0] text_byte,
	input  logic       line_end,
	output res_t       res
);

	pend_t state_q;
	pend_t state_nxt;
	logic  fresh;

	// a byte is taken as the start of a new character
	assign fresh = (state_q == PEND_IDLE) || (state_q == PEND_E2 && line_end) ||
		(state_q != PEND_C3 && state_q != PEND_E2 && state_q != PEND_E2_86 &&
		state_q != PEND_E2_BAD);

	always_comb begin
		state_nxt = PEND_IDLE;
		if (!line_end) begin
			unique case (state_q)
				PEND_C3, PEND_E2_86, PEND_E2_BAD: state_nxt = PEND_IDLE;
				PEND_E2: state_nxt = (text_byte == CONT_86) ? PEND_E2_86 : PEND_E2_BAD;
				default: begin
					if (text_byte == LEAD_C3)
						state_nxt = PEND_C3;
					else if (text_byte == LEAD_E2)
						state_nxt = PEND_E2;
					else
						state_nxt = PEND_IDLE;
				end
			endcase
		end
	end

	always_comb begin
		res.char_valid = 1'b0;
		res.char_code  = '0;
		res.line_done  = line_end;
		if (fresh) begin
			unique case (text_byte)
				CH_BACKSLASH: begin
					res.char_valid = 1'b1;
					res.char_code  = LCD_BACKSLASH;
				end
				CH_TILDE: begin
					res.char_valid = 1'b1;
					res.char_code  = LCD_TILDE;
				end
				LEAD_C3, LEAD_E2: res.char_valid = 1'b0;
				default: begin
					res.char_valid = 1'b1;
					res.char_code  = text_byte;
				end
			endcase
		end else if (state_q == PEND_C3) begin
			res.char_valid = 1'b1;
			unique case (text_byte)
				CONT_AE_LO: res.char_code = LCD_AE_LO;
				CONT_OE_LO: res.char_code = LCD_OE_LO;
				CONT_UE_LO: res.char_code = LCD_UE_LO;
				CONT_AE_UP: res.char_code = LCD_AE_UP;
				CONT_OE_UP: res.char_code = LCD_OE_UP;
				CONT_UE_UP: res.char_code = LCD_UE_UP;
				CONT_SZ:    res.char_code = LCD_SZ;
				default:    res.char_valid = 1'b0;
			endcase
		end else if (state_q == PEND_E2_86) begin
			if (text_byte == CONT_LARROW) begin
				res.char_valid = 1'b1;
				res.char_code  = LCD_LARROW;
			end else if (text_byte == CONT_RARROW) begin
				res.char_valid = 1'b1;
				res.char_code  = LCD_RARROW;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= PEND_IDLE;
		end else if (adv) begin
			state_q <= state_nxt;
		end
	end

	a_line_end_idle: assert property (@(posedge clk) disable iff (!arst_n)
		adv && line_end |=> state_q == PEND_IDLE)
		else $error("sequence pending after line end");

	a_bad_drops: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == PEND_E2_BAD |-> !res.char_valid)
		else $error("unknown sequence emitted a character");

	a_lead_held: assert property (@(posedge clk) disable iff (!arst_n)
		adv && fresh && !line_end && text_byte == LEAD_C3 |=> state_q == PEND_C3)
		else $error("lead byte not recorded");

	a_code_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!res.char_valid |-> res.char_code == '0)
		else $error("code not cleared on dropped byte");

endmodule

// File: sv/u8lcd_out_reg.sv
module u8lcd_out_reg import u8lcd_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  res_t          res,
	output logic          space,
	u8lcd_char_if.source  chars
);

	logic valid_s2;
	res_t res_s2;

	assign space = !valid_s2 || chars.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (space) begin
			valid_s2 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && space) begin
			res_s2 <= res;
		end
	end

	assign chars.valid      = valid_s2;
	assign chars.char_valid = res_s2.char_valid;
	assign chars.char_code  = res_s2.char_code;
	assign chars.line_done  = res_s2.line_done;

endmodule

// File: test/utf8_to_lcd_charset_mapper_top_tb.sv
module utf8_to_lcd_charset_mapper_top_tb;
	import u8lcd_pkg::*;

	localparam int RANDOM_BYTES = 1600;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int IDLE_PCT     = 11;
	localparam int DRAIN_CYCLES = 8;

	typedef struct {
		logic [7:0] b;
		logic       last;
		bit         typed;
		res_t       want;
	} row_t;

	logic clk = 1'b0;
	logic arst_n;

	u8lcd_text_if text_ch();
	u8lcd_char_if char_ch();

	utf8_to_lcd_charset_mapper_top dut (
		.clk   (clk),
		.arst_n(arst_n),
		.text  (text_ch),
		.chars (char_ch)
	);

	pend_t lcd_pend;
	res_t  expected_chars [$];
	int    mismatches;
	int    cycles;
	bit    idle_on;
	bit    pin_exp;
	res_t  pinned_char;

	// directed rows, the typed expectations are the obvious ones only
	row_t plan [0:24] = '{
		'{8'h00,        1'b0, 1'b1, res_t'{1'b1, 8'h00,         1'b0}},
		'{8'hFF,        1'b1, 1'b1, res_t'{1'b1, 8'hFF,         1'b1}},
		'{CH_BACKSLASH, 1'b0, 1'b1, res_t'{1'b1, LCD_BACKSLASH, 1'b0}},
		'{CH_TILDE,     1'b1, 1'b1, res_t'{1'b1, LCD_TILDE,     1'b1}},
		'{LEAD_C3,      1'b0, 1'b1, res_t'{1'b0, 8'h00,         1'b0}},
		'{CONT_AE_LO,   1'b0, 1'b0, res_t'{1'b0, 8'h00,         1'b0}},
		'{LEAD_C3,      1'b0, 1'b0, res_t'{1'b0, 8'h00,         1'b0}},
		'{CONT_SZ,      1'b1, 1'b0, res_t'{1'b0, 8'h00,         1'b0}},
		'{LEAD_E2,      1'b0, 1'b0, res_t'{1'b0, 8'h00,         1'b0}},
		'{CONT_86,      1'b0, 1'b0, res_t'{1'b0, 8'h00,         1'b0}},
		'{CONT_LARROW,  1'b0, 1'b0, res_t'{1'b0, 8'h00,         1'b0}},
		'{LEAD_E2,      1'b0, 1'b0, res_t'{1'b0, 8'h00,         1'b0}},
		'{CONT_86,      1'b0, 1'b0, res_t'{1'b0, 8'h00,         1'b0}},
		'{CONT_RARROW,  1'b1, 1'b0, res_t'{1'b0, 8'h00,         1'b0}},
		// lead bytes with no room left in the line
		'{LEAD_C3,      1'b1, 1'b1, res_t'{1'b0, 8'h00,         1'b1}},
		'{LEAD_E2,      1'b1, 1'b1, res_t'{1'b0, 8'h00,         1'b1}},
		// e2 then line end: the last byte counts as a fresh byte
		'{LEAD_E2,      1'b0, 1'b0, res_t'{1'b0, 8'h00,         1'b0}},
		'{8'h41,        1'b1, 1'b0, res_t'{1'b0, 8'h00,         1'b0}},
		'{LEAD_E2,      1'b0, 1'b0, res_t'{1'b0, 8'h00,         1'b0}},
		'{LEAD_C3,      1'b1, 1'b0, res_t'{1'b0, 8'h00,         1'b0}},
		// unknown c3 pair is swallowed
		'{LEAD_C3,      1'b0, 1'b0, res_t'{1'b0, 8'h00,         1'b0}},
		'{8'h41,        1'b0, 1'b0, res_t'{1'b0, 8'h00,         1'b0}},
		// specials in continuation position are swallowed too
		'{LEAD_E2,      1'b0, 1'b0, res_t'{1'b0, 8'h00,         1'b0}},
		'{CH_BACKSLASH, 1'b0, 1'b0, res_t'{1'b0, 8'h00,         1'b0}},
		'{CH_TILDE,     1'b1, 1'b0, res_t'{1'b0, 8'h00,         1'b0}}
	};

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic res_t map_fresh_byte(logic [7:0] b, logic last);
		res_t r;
		r = '0;
		case (b)
			CH_BACKSLASH: r = res_t'{1'b1, LCD_BACKSLASH, 1'b0};
			CH_TILDE:     r = res_t'{1'b1, LCD_TILDE, 1'b0};
			LEAD_C3:      if (!last) lcd_pend = PEND_C3;
			LEAD_E2:      if (!last) lcd_pend = PEND_E2;
			default:      r = res_t'{1'b1, b, 1'b0};
		endcase
		return r;
	endfunction

	function automatic res_t map_text_byte(logic [7:0] b, logic last);
		res_t  r;
		pend_t was;
		r = '0;
		was = lcd_pend;
		lcd_pend = PEND_IDLE;
		case (was)
			PEND_C3: begin
				r.char_valid = 1'b1;
				case (b)
					CONT_AE_LO: r.char_code = LCD_AE_LO;
					CONT_OE_LO: r.char_code = LCD_OE_LO;
					CONT_UE_LO: r.char_code = LCD_UE_LO;
					CONT_AE_UP: r.char_code = LCD_AE_UP;
					CONT_OE_UP: r.char_code = LCD_OE_UP;
					CONT_UE_UP: r.char_code = LCD_UE_UP;
					CONT_SZ:    r.char_code = LCD_SZ;
					default:    r.char_valid = 1'b0;
				endcase
			end
			PEND_E2: begin
				if (last)
					r = map_fresh_byte(b, 1'b1);
				else
					lcd_pend = (b == CONT_86) ? PEND_E2_86 : PEND_E2_BAD;
			end
			PEND_E2_86: begin
				if (b == CONT_LARROW)
					r = res_t'{1'b1, LCD_LARROW, 1'b0};
				else if (b == CONT_RARROW)
					r = res_t'{1'b1, LCD_RARROW, 1'b0};
			end
			PEND_E2_BAD: ;
			default: r = map_fresh_byte(b, last);
		endcase
		if (last) lcd_pend = PEND_IDLE;
		r.line_done = last;
		return r;
	endfunction

	always @(posedge clk) begin
		res_t want;
		res_t got;
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
		if (text_ch.valid && text_ch.ready) begin
			want = map_text_byte(text_ch.text_byte, text_ch.line_end);
			expected_chars.push_back(pin_exp ? pinned_char : want);
		end
		if (char_ch.valid && char_ch.ready) begin
			got = res_t'{char_ch.char_valid, char_ch.char_code, char_ch.line_done};
			if (expected_chars.size() == 0) begin
				$display("%0t: result with nothing expected: %h", $time, got);
				mismatches++;
			end else begin
				want = expected_chars.pop_front();
				if (got.char_valid !== want.char_valid) begin
					$display("%0t: char_valid expected %b got %b", $time,
						want.char_valid, got.char_valid);
					mismatches++;
				end
				if (got.char_code !== want.char_code) begin
					$display("%0t: char_code expected %h got %h", $time,
						want.char_code, got.char_code);
					mismatches++;
				end
				if (got.line_done !== want.line_done) begin
					$display("%0t: line_done expected %b got %b", $time,
						want.line_done, got.line_done);
					mismatches++;
				end
			end
		end
	end

	// output side stalls
	always @(negedge clk)
		char_ch.ready <= idle_on ? ($urandom_range(99) >= IDLE_PCT) : 1'b1;

	// called at a falling edge, returns at the falling edge after acceptance
	task automatic send_request(logic [7:0] b, logic last, bit typed, res_t want);
		while (idle_on && $urandom_range(99) < IDLE_PCT) begin
			text_ch.valid <= 1'b0;
			@(negedge clk);
		end
		pin_exp = typed;
		pinned_char = want;
		text_ch.valid <= 1'b1;
		text_ch.text_byte <= b;
		text_ch.line_end <= last;
		do @(posedge clk); while (!text_ch.ready);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		text_ch.valid <= 1'b0;
		while (expected_chars.size() != 0) @(negedge clk);
	endtask

	// mostly well-formed sequences, some noise, line end breaks them at random
	task automatic send_random_sequence(inout int sent);
		logic [7:0] seq [$];
		logic [7:0] tail;
		int         kind;
		kind = $urandom_range(99);
		if (kind < 30) begin
			seq.push_back(8'($urandom_range(255)));
		end else if (kind < 50) begin
			case ($urandom_range(7))
				0: tail = CONT_AE_LO;
				1: tail = CONT_OE_LO;
				2: tail = CONT_UE_LO;
				3: tail = CONT_AE_UP;
				4: tail = CONT_OE_UP;
				5: tail = CONT_UE_UP;
				6: tail = CONT_SZ;
				default: tail = 8'($urandom_range(255));
			endcase
			seq.push_back(LEAD_C3);
			seq.push_back(tail);
		end else if (kind < 65) begin
			seq.push_back(LEAD_E2);
			seq.push_back(CONT_86);
			seq.push_back($urandom_range(1) ? CONT_LARROW : CONT_RARROW);
		end else if (kind < 75) begin
			seq.push_back(LEAD_E2);
			seq.push_back(8'($urandom_range(255)));
			seq.push_back(8'($urandom_range(255)));
		end else if (kind < 85) begin
			seq.push_back($urandom_range(1) ? CH_BACKSLASH : CH_TILDE);
		end else begin
			seq.push_back($urandom_range(1) ? LEAD_C3 : LEAD_E2);
		end
		foreach (seq[i]) begin
			idle_on = !(sent >= 700 && sent < 1000);
			send_request(seq[i], $urandom_range(9) == 0, 1'b0, '0);
			sent++;
		end
	endtask

	initial begin
		int  sent;
		bit  paused;
		arst_n = 1'b0;
		text_ch.valid = 1'b0;
		text_ch.text_byte = '0;
		text_ch.line_end = 1'b0;
		char_ch.ready = 1'b0;
		lcd_pend = PEND_IDLE;
		mismatches = 0;
		cycles = 0;
		idle_on = 1'b1;
		pin_exp = 1'b0;
		pinned_char = '0;
		sent = 0;
		paused = 1'b0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (plan[i])
			send_request(plan[i].b, plan[i].last, plan[i].typed, plan[i].want);
		wait_drained();
		@(negedge clk);

		while (sent < RANDOM_BYTES) begin
			send_random_sequence(sent);
			if (!paused && sent >= 400) begin
				wait_drained();
				@(negedge clk);
				paused = 1'b1;
			end
		end
		idle_on = 1'b1;
		wait_drained();
		repeat (DRAIN_CYCLES) @(negedge clk);

		if (mismatches == 0 && expected_chars.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

// File: sim.f
sv/u8lcd_pkg.sv
sv/u8lcd_ifs.sv
sv/u8lcd_seq.sv
sv/u8lcd_out_reg.sv
sv/utf8_to_lcd_charset_mapper_top.sv
test/utf8_to_lcd_charset_mapper_top_tb.sv
